// File: sv/shfd_pkg.sv
package shfd_pkg;

   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam int unsigned CMD_W = 16;
   localparam int unsigned HDR_LEN_W = 16;
   localparam int unsigned TAIL_W = 32;
   localparam int unsigned CAP_W = 13;
   localparam int unsigned OUT_LEN_W = 13;
   localparam int unsigned OUT_IDX_W = 13;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [7:0] SYNC_A = 8'hA5;
   localparam logic [7:0] SYNC_B = 8'h5A;

   localparam logic [3:0] HDR_FIRST  = 4'd4;
   localparam logic [3:0] HDR_CMD_LO = 4'd6;
   localparam logic [3:0] HDR_CMD_HI = 4'd7;
   localparam logic [3:0] HDR_LEN_LO = 4'd8;
   localparam logic [3:0] HDR_LEN_HI = 4'd9;
   localparam logic [3:0] HDR_TAIL0  = 4'd12;
   localparam logic [3:0] HDR_TAIL1  = 4'd13;
   localparam logic [3:0] HDR_TAIL2  = 4'd14;
   localparam logic [3:0] HDR_LAST   = 4'(HEADER_BYTES - 1);

   localparam logic [CMD_W-1:0]  AUDIO_CMD_RESET   = 16'h0E21;
   localparam logic [TAIL_W-1:0] TAIL_WORD_RESET   = 32'h1234_5678;
   localparam logic [CAP_W-1:0]  PAYLOAD_CAP_RESET = 13'd128;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_AUDIO_CMD   = 2'd0,
      REG_TAIL_WORD   = 2'd1,
      REG_PAYLOAD_CAP = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_LERR  = 2'd2
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type        kind;
      logic [7:0]            data;
      logic [HDR_LEN_W-1:0]  idx;
      logic                  fend;
      logic [CMD_W-1:0]      cmd;
      logic [HDR_LEN_W-1:0]  len;
      logic [TAIL_W-1:0]     tail;
   } entry_type;

endpackage

// File: sv/shfd_front.sv
module shfd_front #(
   parameter int unsigned MAX_PAYLOAD = 4112
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic                q_full,
   output logic                q_push,
   output shfd_pkg::entry_type q_entry
);

   localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

   typedef enum logic [5:0] {
      PH_HUNT0   = 6'b000001,
      PH_HUNT1   = 6'b000010,
      PH_HUNT2   = 6'b000100,
      PH_HUNT3   = 6'b001000,
      PH_HEADER  = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [3:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic [LEN_W-1:0] pay_cnt_ff, pay_cnt_in;
   logic [LEN_W-1:0] pay_cnt_next;
   logic [7:0]       cmd_lo_ff, cmd_hi_ff, len_lo_ff, len_hi_ff;
   logic [7:0]       tail0_ff, tail1_ff, tail2_ff, tail3_ff;
   logic [shfd_pkg::HDR_LEN_W-1:0] hdr_len;
   logic             accept;
   logic             fend;

   assign req_ready    = ~q_full;
   assign accept       = req_valid & ~q_full;
   assign hdr_len      = {len_hi_ff, len_lo_ff};
   assign pay_cnt_next = pay_cnt_ff + 1'b1;
   assign fend         = (pay_cnt_next == frame_len_ff);

   always_comb begin
      phase_in             = phase_ff;
      hdr_cnt_in           = hdr_cnt_ff;
      frame_len_in         = frame_len_ff;
      pay_cnt_in           = pay_cnt_ff;
      q_push               = 1'b0;
      q_entry.kind         = shfd_pkg::KIND_DATA;
      q_entry.data         = 8'd0;
      q_entry.idx          = '0;
      q_entry.fend         = 1'b0;
      q_entry.cmd          = {cmd_hi_ff, cmd_lo_ff};
      q_entry.len          = hdr_len;
      q_entry.tail         = {tail3_ff, tail2_ff, tail1_ff, tail0_ff};
      if (accept) begin
         case (phase_ff)
            PH_HUNT0: begin
               if (req_rx_byte == shfd_pkg::SYNC_A) begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_HUNT1: begin
               phase_in = (req_rx_byte == shfd_pkg::SYNC_A) ? PH_HUNT2 : PH_HUNT0;
            end
            PH_HUNT2: begin
               if (req_rx_byte == shfd_pkg::SYNC_B) begin
                  phase_in = PH_HUNT3;
               end else if (req_rx_byte == shfd_pkg::SYNC_A) begin
                  phase_in = PH_HUNT1;
               end else begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_HUNT3: begin
               if (req_rx_byte == shfd_pkg::SYNC_B) begin
                  phase_in   = PH_HEADER;
                  hdr_cnt_in = shfd_pkg::HDR_FIRST;
               end else if (req_rx_byte == shfd_pkg::SYNC_A) begin
                  phase_in = PH_HUNT1;
               end else begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_HEADER: begin
               hdr_cnt_in = hdr_cnt_ff + 1'b1;
               if (hdr_cnt_ff == shfd_pkg::HDR_LAST) begin
                  q_entry.tail = {req_rx_byte, tail2_ff, tail1_ff, tail0_ff};
                  pay_cnt_in   = '0;
                  if (32'(hdr_len) > 32'(MAX_PAYLOAD)) begin
                     q_push       = 1'b1;
                     q_entry.kind = shfd_pkg::KIND_LERR;
                     phase_in     = PH_HUNT0;
                  end else if (hdr_len == '0) begin
                     q_push       = 1'b1;
                     q_entry.kind = shfd_pkg::KIND_EMPTY;
                     q_entry.fend = 1'b1;
                     phase_in     = PH_HUNT0;
                  end else begin
                     frame_len_in = LEN_W'(hdr_len);
                     phase_in     = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               q_push       = 1'b1;
               q_entry.kind = shfd_pkg::KIND_DATA;
               q_entry.data = req_rx_byte;
               q_entry.idx  = shfd_pkg::HDR_LEN_W'(pay_cnt_ff);
               q_entry.fend = fend;
               pay_cnt_in   = pay_cnt_next;
               if (fend) begin
                  phase_in = PH_HUNT0;
               end
            end
            default: begin
               phase_in = PH_HUNT0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT0;
         hdr_cnt_ff   <= '0;
         frame_len_ff <= '0;
         pay_cnt_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         frame_len_ff <= frame_len_in;
         pay_cnt_ff   <= pay_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_HEADER) begin
         case (hdr_cnt_ff)
            shfd_pkg::HDR_CMD_LO: cmd_lo_ff <= req_rx_byte;
            shfd_pkg::HDR_CMD_HI: cmd_hi_ff <= req_rx_byte;
            shfd_pkg::HDR_LEN_LO: len_lo_ff <= req_rx_byte;
            shfd_pkg::HDR_LEN_HI: len_hi_ff <= req_rx_byte;
            shfd_pkg::HDR_TAIL0:  tail0_ff  <= req_rx_byte;
            shfd_pkg::HDR_TAIL1:  tail1_ff  <= req_rx_byte;
            shfd_pkg::HDR_TAIL2:  tail2_ff  <= req_rx_byte;
            shfd_pkg::HDR_LAST:   tail3_ff  <= req_rx_byte;
            default: begin
            end
         endcase
      end
   end

   a_payload_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (pay_cnt_ff < frame_len_ff))
      else $error("payload count reached the frame length inside a frame");

endmodule

// File: sv/shfd_fifo.sv
module shfd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  shfd_pkg::entry_type push_entry,
   input  logic                pop,
   output shfd_pkg::entry_type pop_entry,
   output logic                full,
   output logic                empty
);

   localparam int unsigned DEPTH = shfd_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   shfd_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds its depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

// File: sv/shfd_back.sv
module shfd_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [shfd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [shfd_pkg::TAIL_W-1:0]            csr_data,
   input  logic                                   q_empty,
   input  shfd_pkg::entry_type                    q_entry,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_data_byte,
   output logic                                   rsp_data_valid,
   output logic [shfd_pkg::OUT_IDX_W-1:0]         rsp_byte_index,
   output logic [shfd_pkg::CMD_W-1:0]             rsp_command,
   output logic [shfd_pkg::OUT_LEN_W-1:0]         rsp_frame_length,
   output logic                                   rsp_frame_end,
   output logic                                   rsp_tail_ok,
   output logic                                   rsp_is_audio,
   output logic                                   rsp_payload_kept,
   output logic                                   rsp_length_error
);

   logic [shfd_pkg::CMD_W-1:0]  audio_cmd_ff;
   logic [shfd_pkg::TAIL_W-1:0] tail_word_ff;
   logic [shfd_pkg::CAP_W-1:0]  cap_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [7:0]                          data_ff, data_in;
   logic                                dvalid_ff, dvalid_in;
   logic [shfd_pkg::OUT_IDX_W-1:0]      idx_ff, idx_in;
   logic [shfd_pkg::CMD_W-1:0]          cmd_ff;
   logic [shfd_pkg::OUT_LEN_W-1:0]      len_ff;
   logic                                fend_ff, fend_in;
   logic                                tok_ff, tok_in;
   logic                                audio_ff, audio_in;
   logic                                kept_ff, kept_in;
   logic                                lerr_ff, lerr_in;
   logic                                len_fits;
   logic                                idx_fits;
   logic                                tail_match;

   assign csr_ready  = 1'b1;
   assign audio_in   = (q_entry.cmd == audio_cmd_ff);
   assign len_fits   = (q_entry.len <= shfd_pkg::HDR_LEN_W'(cap_ff));
   assign idx_fits   = (q_entry.idx < shfd_pkg::HDR_LEN_W'(cap_ff));
   assign tail_match = (q_entry.tail == tail_word_ff);

   assign q_pop        = ~q_empty & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid_in = q_pop | (rsp_valid_ff & ~rsp_ready);

   always_comb begin
      data_in   = 8'd0;
      dvalid_in = 1'b0;
      idx_in    = '0;
      fend_in   = 1'b0;
      tok_in    = 1'b0;
      kept_in   = 1'b0;
      lerr_in   = 1'b0;
      case (q_entry.kind)
         shfd_pkg::KIND_DATA: begin
            data_in   = q_entry.data;
            dvalid_in = audio_in | idx_fits;
            idx_in    = shfd_pkg::OUT_IDX_W'(q_entry.idx);
            fend_in   = q_entry.fend;
            tok_in    = tail_match;
            kept_in   = audio_in | len_fits;
         end
         shfd_pkg::KIND_EMPTY: begin
            fend_in = 1'b1;
            tok_in  = tail_match;
            kept_in = audio_in | len_fits;
         end
         shfd_pkg::KIND_LERR: begin
            lerr_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_cmd_ff <= shfd_pkg::AUDIO_CMD_RESET;
         tail_word_ff <= shfd_pkg::TAIL_WORD_RESET;
         cap_ff       <= shfd_pkg::PAYLOAD_CAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            shfd_pkg::REG_AUDIO_CMD:   audio_cmd_ff <= csr_data[shfd_pkg::CMD_W-1:0];
            shfd_pkg::REG_TAIL_WORD:   tail_word_ff <= csr_data;
            shfd_pkg::REG_PAYLOAD_CAP: cap_ff       <= csr_data[shfd_pkg::CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff   <= data_in;
         dvalid_ff <= dvalid_in;
         idx_ff    <= idx_in;
         cmd_ff    <= q_entry.cmd;
         len_ff    <= q_entry.len[shfd_pkg::OUT_LEN_W-1:0];
         fend_ff   <= fend_in;
         tok_ff    <= tok_in;
         audio_ff  <= audio_in;
         kept_ff   <= kept_in;
         lerr_ff   <= lerr_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_data_valid   = dvalid_ff;
   assign rsp_byte_index   = idx_ff;
   assign rsp_command      = cmd_ff;
   assign rsp_frame_length = len_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_tail_ok      = tok_ff;
   assign rsp_is_audio     = audio_ff;
   assign rsp_payload_kept = kept_ff;
   assign rsp_length_error = lerr_ff;

endmodule

// File: sv/sync_header_frame_deframer.sv
// Channel    Direction  Ports
// req        in         req_valid, req_ready, req_rx_byte
// rsp        out        rsp_valid, rsp_ready, rsp_data_byte .. rsp_length_error
// csr        in         csr_valid, csr_ready, csr_index, csr_data
//
// One request is accepted per cycle while the queue is not full; each accepted byte updates the registered parse state.
// A response passes from the request that causes it through the two-entry queue and then
// the output register.
// Reset is synchronous and active high; it restores the register defaults and the hunt state.
// The input stalls only when the queue is full. With a payload byte every cycle the queue holds
// one entry, so rsp_ready low while a response waits stalls the next request.
module sync_header_frame_deframer #(
   parameter int unsigned MAX_PAYLOAD = 4112
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_data_byte,
   output logic                               rsp_data_valid,
   output logic [shfd_pkg::OUT_IDX_W-1:0]     rsp_byte_index,
   output logic [shfd_pkg::CMD_W-1:0]         rsp_command,
   output logic [shfd_pkg::OUT_LEN_W-1:0]     rsp_frame_length,
   output logic                               rsp_frame_end,
   output logic                               rsp_tail_ok,
   output logic                               rsp_is_audio,
   output logic                               rsp_payload_kept,
   output logic                               rsp_length_error,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [shfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [shfd_pkg::TAIL_W-1:0]        csr_data
);

   logic                q_full;
   logic                q_empty;
   logic                q_push;
   logic                q_pop;
   shfd_pkg::entry_type push_entry;
   shfd_pkg::entry_type pop_entry;

   shfd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   shfd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   shfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_empty          (q_empty),
      .q_entry          (pop_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_command      (rsp_command),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_tail_ok      (rsp_tail_ok),
      .rsp_is_audio     (rsp_is_audio),
      .rsp_payload_kept (rsp_payload_kept),
      .rsp_length_error (rsp_length_error)
   );

endmodule

// File: bench/tb_sync_header_frame_deframer.sv
`timescale 1ns / 1ps

module tb_sync_header_frame_deframer;

   localparam int unsigned MAX_PAYLOAD = 4112;
   localparam int RANDOM_BYTES = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 50000;

   typedef enum logic [5:0] {
      HUNT0      = 6'b000001,
      HUNT1      = 6'b000010,
      HUNT2      = 6'b000100,
      HUNT3      = 6'b001000,
      IN_HEADER  = 6'b010000,
      IN_PAYLOAD = 6'b100000
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]                     data_byte;
      logic                           data_valid;
      logic [shfd_pkg::OUT_IDX_W-1:0] byte_index;
      logic [shfd_pkg::CMD_W-1:0]     command;
      logic [shfd_pkg::OUT_LEN_W-1:0] frame_length;
      logic                           frame_end;
      logic                           tail_ok;
      logic                           is_audio;
      logic                           payload_kept;
      logic                           length_error;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic rsp_data_valid;
   logic [shfd_pkg::OUT_IDX_W-1:0] rsp_byte_index;
   logic [shfd_pkg::CMD_W-1:0] rsp_command;
   logic [shfd_pkg::OUT_LEN_W-1:0] rsp_frame_length;
   logic rsp_frame_end;
   logic rsp_tail_ok;
   logic rsp_is_audio;
   logic rsp_payload_kept;
   logic rsp_length_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   shfd_pkg::csr_index_type csr_index = shfd_pkg::REG_AUDIO_CMD;
   logic [shfd_pkg::TAIL_W-1:0] csr_data = '0;

   logic [shfd_pkg::CMD_W-1:0] audio_cmd = shfd_pkg::AUDIO_CMD_RESET;
   logic [shfd_pkg::TAIL_W-1:0] tail_word = shfd_pkg::TAIL_WORD_RESET;
   logic [shfd_pkg::CAP_W-1:0] payload_cap = shfd_pkg::PAYLOAD_CAP_RESET;

   parse_phase_type phase = HUNT0;
   int hdr_count = 0;
   logic [7:0] hdr_store [12];
   logic [shfd_pkg::CMD_W-1:0] frame_cmd = '0;
   logic [15:0] frame_len = '0;
   logic [15:0] pay_count = '0;

   frame_result_type deframed_q[$];
   int mismatch_count = 0;
   int bytes_sent = 0;
   int burst_left = 0;
   logic [31:0] cycle_count = '0;
   int ready_mode = 0;

   sync_header_frame_deframer #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data_byte(rsp_data_byte),
      .rsp_data_valid(rsp_data_valid),
      .rsp_byte_index(rsp_byte_index),
      .rsp_command(rsp_command),
      .rsp_frame_length(rsp_frame_length),
      .rsp_frame_end(rsp_frame_end),
      .rsp_tail_ok(rsp_tail_ok),
      .rsp_is_audio(rsp_is_audio),
      .rsp_payload_kept(rsp_payload_kept),
      .rsp_length_error(rsp_length_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycle_count % 97 == 0) begin
         ready_mode <= $urandom_range(0, 3);
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= (cycle_count % 5 != 0);
         default: rsp_ready <= cycle_count[3];
      endcase
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic frame_result_type make_result(input logic [7:0] data, input logic valid,
                                                    input logic [15:0] idx, input logic fend,
                                                    input logic tok, input logic kept,
                                                    input logic lerr);
      frame_result_type r;
      r.data_byte = data;
      r.data_valid = valid;
      r.byte_index = idx[shfd_pkg::OUT_IDX_W-1:0];
      r.command = frame_cmd;
      r.frame_length = frame_len[shfd_pkg::OUT_LEN_W-1:0];
      r.frame_end = fend;
      r.tail_ok = tok;
      r.is_audio = (frame_cmd == audio_cmd);
      r.payload_kept = kept;
      r.length_error = lerr;
      return r;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      logic audio;
      logic tail_match;
      logic kept;
      logic [15:0] idx;
      case (phase)
         HUNT0: begin
            if (b == shfd_pkg::SYNC_A) phase = HUNT1;
         end
         HUNT1: begin
            phase = (b == shfd_pkg::SYNC_A) ? HUNT2 : HUNT0;
         end
         HUNT2, HUNT3: begin
            if (b == shfd_pkg::SYNC_B) begin
               if (phase == HUNT3) begin
                  hdr_count = 4;
                  phase = IN_HEADER;
               end else begin
                  phase = HUNT3;
               end
            end else if (b == shfd_pkg::SYNC_A) begin
               phase = HUNT1;
            end else begin
               phase = HUNT0;
            end
         end
         IN_HEADER: begin
            hdr_store[hdr_count - 4] = b;
            hdr_count++;
            if (hdr_count == shfd_pkg::HEADER_BYTES) begin
               hdr_count = 0;
               frame_cmd = {hdr_store[3], hdr_store[2]};
               frame_len = {hdr_store[5], hdr_store[4]};
               pay_count = '0;
               audio = (frame_cmd == audio_cmd);
               tail_match = ({hdr_store[11], hdr_store[10], hdr_store[9], hdr_store[8]}
                             == tail_word);
               kept = audio || (frame_len <= 16'(payload_cap));
               if (frame_len > MAX_PAYLOAD) begin
                  phase = HUNT0;
                  deframed_q.push_back(make_result(8'h00, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0,
                                                   1'b1));
               end else if (frame_len == 0) begin
                  phase = HUNT0;
                  deframed_q.push_back(make_result(8'h00, 1'b0, 16'd0, 1'b1, tail_match,
                                                   kept, 1'b0));
               end else begin
                  phase = IN_PAYLOAD;
               end
            end
         end
         IN_PAYLOAD: begin
            audio = (frame_cmd == audio_cmd);
            tail_match = ({hdr_store[11], hdr_store[10], hdr_store[9], hdr_store[8]}
                          == tail_word);
            kept = audio || (frame_len <= 16'(payload_cap));
            idx = pay_count;
            pay_count = pay_count + 1;
            if (pay_count >= frame_len) phase = HUNT0;
            deframed_q.push_back(make_result(b, audio || (idx < 16'(payload_cap)), idx,
                                             pay_count >= frame_len, tail_match, kept,
                                             1'b0));
         end
         default: phase = HUNT0;
      endcase
   endfunction

   function automatic string describe(input frame_result_type r);
      return {$sformatf("data=%h dv=%b idx=%0d cmd=%h len=%0d ", r.data_byte, r.data_valid,
                        r.byte_index, r.command, r.frame_length),
              $sformatf("end=%b tail=%b audio=%b kept=%b lerr=%b", r.frame_end, r.tail_ok,
                        r.is_audio, r.payload_kept, r.length_error)};
   endfunction

   always @(posedge clock) begin : check_results
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.data_byte = rsp_data_byte;
         got.data_valid = rsp_data_valid;
         got.byte_index = rsp_byte_index;
         got.command = rsp_command;
         got.frame_length = rsp_frame_length;
         got.frame_end = rsp_frame_end;
         got.tail_ok = rsp_tail_ok;
         got.is_audio = rsp_is_audio;
         got.payload_kept = rsp_payload_kept;
         got.length_error = rsp_length_error;
         if (deframed_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected result: %s", describe(got));
            end
         end else begin
            want = deframed_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch at cycle %0d", cycle_count);
                  $display("  expected %s", describe(want));
                  $display("  actual   %s", describe(got));
               end
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      deframe_byte(value);
   endtask

   task automatic send_pattern(input logic [31:0] pattern, input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(pattern[31 - 8 * i -: 8]);
      end
   endtask

   task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len,
                             input logic [31:0] tail, input int n_payload);
      send_pattern({shfd_pkg::SYNC_A, shfd_pkg::SYNC_A, shfd_pkg::SYNC_B, shfd_pkg::SYNC_B}, 4);
      send_byte(rand_byte());
      send_byte(rand_byte());
      send_pattern({cmd[7:0], cmd[15:8], len[7:0], len[15:8]}, 4);
      send_byte(rand_byte());
      send_byte(rand_byte());
      send_pattern({tail[7:0], tail[15:8], tail[23:16], tail[31:24]}, 4);
      repeat (n_payload) send_byte(rand_byte());
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input shfd_pkg::csr_index_type index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         shfd_pkg::REG_AUDIO_CMD: audio_cmd = value[shfd_pkg::CMD_W-1:0];
         shfd_pkg::REG_TAIL_WORD: tail_word = value;
         shfd_pkg::REG_PAYLOAD_CAP: payload_cap = value[shfd_pkg::CAP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] cmd, input logic [31:0] tail,
                             input logic [12:0] cap);
      wait_results_drained();
      write_reg(shfd_pkg::REG_AUDIO_CMD, {16'h0000, cmd});
      write_reg(shfd_pkg::REG_TAIL_WORD, tail);
      write_reg(shfd_pkg::REG_PAYLOAD_CAP, {19'd0, cap});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_sync_hunting();
      send_pattern({8'h00, shfd_pkg::SYNC_A, shfd_pkg::SYNC_B, shfd_pkg::SYNC_B}, 4);
      send_frame(16'h0001, 16'd2, tail_word, 2);
      send_pattern({shfd_pkg::SYNC_A, shfd_pkg::SYNC_A, 8'h00, 8'hFF}, 4);
      send_frame(16'h0002, 16'd1, tail_word, 1);
      send_pattern({4{shfd_pkg::SYNC_A}}, 4);
      send_pattern({shfd_pkg::SYNC_B, shfd_pkg::SYNC_B, 16'h0000}, 2);
      repeat (12) send_byte(8'h00);
      send_pattern({shfd_pkg::SYNC_A, shfd_pkg::SYNC_A, shfd_pkg::SYNC_B, shfd_pkg::SYNC_A}, 4);
      send_pattern({shfd_pkg::SYNC_A, shfd_pkg::SYNC_B, shfd_pkg::SYNC_B, 8'h00}, 3);
      repeat (12) send_byte(8'h00);
      send_pattern({shfd_pkg::SYNC_A, shfd_pkg::SYNC_A, shfd_pkg::SYNC_B, 8'h00}, 4);
      send_frame(16'h0003, 16'd3, tail_word, 3);
      wait_results_drained();
   endtask

   task automatic test_frame_fields();
      send_frame(16'h0010, 16'd0, tail_word, 0);
      send_frame(audio_cmd, 16'd0, ~tail_word, 0);
      send_frame(16'hFFFF, 16'd1, 32'h0000_0000, 1);
      send_frame(16'h0013, 16'(MAX_PAYLOAD + 1), tail_word, 0);
      send_frame(audio_cmd, 16'hFFFF, tail_word, 0);
      send_frame(16'h0014, 16'h2005, tail_word, 2);
      wait_results_drained();
   endtask

   task automatic test_payload_cap();
      set_config(shfd_pkg::AUDIO_CMD_RESET, shfd_pkg::TAIL_WORD_RESET, 13'd4);
      send_frame(16'h0011, 16'd4, tail_word, 4);
      send_frame(16'h0012, 16'd5, tail_word, 5);
      send_frame(audio_cmd, 16'd6, tail_word, 6);
      wait_results_drained();
   endtask

   task automatic test_register_extremes();
      set_config(16'h0000, 32'h0000_0000, 13'd0);
      send_frame(16'h0000, 16'd3, 32'h0000_0000, 3);
      send_frame(16'h0001, 16'd2, 32'h0000_0000, 2);
      send_frame(16'h0001, 16'd0, 32'h0000_0001, 0);
      set_config(16'hFFFF, 32'hFFFF_FFFF, 13'(MAX_PAYLOAD));
      send_frame(16'h0001, 16'd10, 32'hFFFF_FFFF, 10);
      send_frame(16'hFFFF, 16'd2, 32'hFFFF_FFFF, 2);
      send_frame(shfd_pkg::AUDIO_CMD_RESET, 16'd1, shfd_pkg::TAIL_WORD_RESET, 1);
   endtask

   function automatic logic [15:0] pick_len();
      int sel;
      int lo;
      sel = $urandom_range(0, 9);
      lo = (payload_cap > 1) ? int'(payload_cap) - 1 : 0;
      if (sel < 6) return 16'($urandom_range(0, 24));
      if (sel < 8 && payload_cap <= 40) begin
         return 16'($urandom_range(lo, int'(payload_cap) + 2));
      end
      return 16'($urandom_range(25, 40));
   endfunction

   function automatic logic [15:0] pick_cmd();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) return audio_cmd;
      if (sel == 3) return 16'h0000;
      if (sel == 4) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic random_traffic(input int n_bytes);
      int start;
      int sel;
      logic [15:0] len;
      logic [31:0] tail;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         sel = $urandom_range(0, 19);
         tail = ($urandom_range(0, 3) != 0) ? tail_word : $urandom;
         len = pick_len();
         if (sel < 13) begin
            send_frame(pick_cmd(), len, tail, int'(len));
         end else if (sel < 15) begin
            send_frame(pick_cmd(), 16'($urandom_range(MAX_PAYLOAD + 1, 65535)), tail,
                       int'($urandom_range(0, 3)));
         end else if (sel < 17) begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 2))
                  0: send_byte(shfd_pkg::SYNC_A);
                  1: send_byte(shfd_pkg::SYNC_B);
                  default: send_byte(rand_byte());
               endcase
            end
         end else if (sel < 19) begin
            send_pattern({shfd_pkg::SYNC_A, shfd_pkg::SYNC_A, shfd_pkg::SYNC_B,
                          shfd_pkg::SYNC_B}, int'($urandom_range(1, 3)));
            send_byte(rand_byte());
         end else begin
            len = 16'($urandom_range(10, 40));
            send_frame(pick_cmd(), len, tail, int'($urandom_range(0, int'(len) - 1)));
         end
      end
   endtask

   task automatic test_random_traffic();
      set_config(shfd_pkg::AUDIO_CMD_RESET, shfd_pkg::TAIL_WORD_RESET,
                 shfd_pkg::PAYLOAD_CAP_RESET);
      random_traffic(RANDOM_BYTES / 3);
      wait_results_drained();
      random_traffic(RANDOM_BYTES / 6);
      set_config(16'($urandom_range(0, 65535)), $urandom, 13'($urandom_range(0, 40)));
      random_traffic(RANDOM_BYTES / 3);
      set_config(16'($urandom_range(0, 65535)), $urandom,
                 13'($urandom_range(41, MAX_PAYLOAD)));
      random_traffic(RANDOM_BYTES / 6);
   endtask

   initial begin
      for (int i = 0; i < 12; i++) hdr_store[i] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_sync_hunting();
      test_frame_fields();
      test_payload_cap();
      test_register_extremes();
      test_random_traffic();
      wait_results_drained();
      if (mismatch_count == 0 && deframed_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
